@@ rtl/core/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Default sizes, used as parameter defaults on the top level.
    localparam int DEPTH_DEF      = 64;
    localparam int PRIO_WIDTH_DEF = 16;
    localparam int CELL_WIDTH_DEF = 16;
    localparam int CNT_WIDTH_DEF  = $clog2(DEPTH_DEF + 1);

    // Operation codes carried by an input item.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Status reported with every result item.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Commands broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ rtl/core/spq_if.sv @@
// Valid/ready channel interfaces for the sorted priority queue.
// Depends on spq_pkg for widths and the status type.
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if #(
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
    parameter int CELL_WIDTH = spq_pkg::CELL_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [PRIO_WIDTH-1:0] priority_req;
    logic [CELL_WIDTH-1:0] cell_index;

    modport source (output valid, output op, output priority_req, output cell_index,
                    input ready);
    modport sink   (input valid, input op, input priority_req, input cell_index,
                    output ready);
endinterface

interface spq_out_if #(
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
    parameter int CELL_WIDTH = spq_pkg::CELL_WIDTH_DEF,
    parameter int CNT_WIDTH  = spq_pkg::CNT_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  head_valid;
    logic [CELL_WIDTH-1:0] head_cell;
    logic [PRIO_WIDTH-1:0] head_priority;
    logic [CNT_WIDTH-1:0]  entry_count;
    spq_pkg::t_status      status;

    modport source (output valid, output head_valid, output head_cell,
                    output head_priority, output entry_count, output status,
                    input ready);
    modport sink   (input valid, input head_valid, input head_cell,
                    input head_priority, input entry_count, input status,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
    parameter int CELL_WIDTH = spq_pkg::CELL_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire spq_pkg::t_cell_ctrl   i_ctrl,
    input  wire logic                  i_occupied,
    input  wire logic [PRIO_WIDTH-1:0] i_new_prio,
    input  wire logic [CELL_WIDTH-1:0] i_new_cell,
    input  wire logic                  i_left_place,
    input  wire logic [PRIO_WIDTH-1:0] i_left_prio,
    input  wire logic [CELL_WIDTH-1:0] i_left_cell,
    input  wire logic [PRIO_WIDTH-1:0] i_right_prio,
    input  wire logic [CELL_WIDTH-1:0] i_right_cell,
    output logic                       o_place,
    output logic [PRIO_WIDTH-1:0]      o_prio,
    output logic [CELL_WIDTH-1:0]      o_cell
);

    logic [PRIO_WIDTH-1:0] r_prio;
    logic [CELL_WIDTH-1:0] r_cell;

    // The new entry belongs at or before this slot when the slot is free
    // or holds a priority greater than or equal to the new one.
    assign o_place = !i_occupied || (r_prio >= i_new_prio);
    assign o_prio  = r_prio;
    assign o_cell  = r_cell;

    // On insert the first placing slot takes the new entry and later ones
    // shift right; on pop every slot takes its right neighbor's entry.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && o_place) begin
            if (i_left_place) begin
                r_prio <= i_left_prio;
                r_cell <= i_left_cell;
            end else begin
                r_prio <= i_new_prio;
                r_cell <= i_new_cell;
            end
        end else if (i_ctrl.pop) begin
            r_prio <= i_right_prio;
            r_cell <= i_right_cell;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sorted_priority_queue_top.sv @@
// Sorted priority queue: a chain of DEPTH cells kept in ascending priority order.
// An item is taken and its result is offered in the next cycle; the
// next item is taken only once that result leaves, so the queue works on one
// item at a time. All slots compare in parallel in the accept cycle.
// Reset (synchronous, active low) empties the queue and drops any pending result.
// Depends on spq_pkg, spq_if and spq_cell.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_top #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
    parameter int CELL_WIDTH = spq_pkg::CELL_WIDTH_DEF,
    parameter int CNT_WIDTH  = $clog2(DEPTH + 1)
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(DEPTH);

    logic                   r_out_valid;
    logic [CNT_WIDTH-1:0]   r_count;
    logic [CNT_WIDTH-1:0]   n_count;
    spq_pkg::t_status       r_status;
    spq_pkg::t_status       n_status;
    spq_pkg::t_cell_ctrl    ctrl;
    logic                   accept;
    logic                   is_full;
    logic                   is_empty;

    logic [DEPTH-1:0]       place;
    logic [PRIO_WIDTH-1:0]  slot_prio [DEPTH];
    logic [CELL_WIDTH-1:0]  slot_cell [DEPTH];

    // One item at a time: a new item waits until the last result is taken.
    assign i_in.ready = !r_out_valid;
    assign accept     = i_in.valid && i_in.ready;
    assign is_full    = (r_count == FULL_COUNT);
    assign is_empty   = (r_count == '0);

    // Commands to the chain; a full insert or an empty pop changes nothing.
    always_comb begin
        ctrl.ins = accept && (i_in.op == spq_pkg::OP_INSERT) && !is_full;
        ctrl.pop = accept && (i_in.op == spq_pkg::OP_POP) && !is_empty;
    end

    // Next count and status of the item being taken.
    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        if (i_in.op == spq_pkg::OP_INSERT) begin
            if (is_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_WIDTH'(1);
            end
        end else begin
            if (is_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_count = r_count - CNT_WIDTH'(1);
            end
        end
    end

    // Control registers: count, pending result and its status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_status    <= spq_pkg::ST_OK;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_status    <= n_status;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The chain of cells; slot 0 is the head.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam logic [CNT_WIDTH-1:0] K_IDX = CNT_WIDTH'(k);
        logic                  left_place;
        logic [PRIO_WIDTH-1:0] left_prio;
        logic [CELL_WIDTH-1:0] left_cell;
        logic [PRIO_WIDTH-1:0] right_prio;
        logic [CELL_WIDTH-1:0] right_cell;

        if (k == 0) begin : g_first
            assign left_place = 1'b0;
            assign left_prio  = '0;
            assign left_cell  = '0;
        end else begin : g_mid
            assign left_place = place[k-1];
            assign left_prio  = slot_prio[k-1];
            assign left_cell  = slot_cell[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign right_prio = '0;
            assign right_cell = '0;
        end else begin : g_inner
            assign right_prio = slot_prio[k+1];
            assign right_cell = slot_cell[k+1];
        end

        spq_cell #(
            .PRIO_WIDTH (PRIO_WIDTH),
            .CELL_WIDTH (CELL_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_occupied   (K_IDX < r_count),
            .i_new_prio   (i_in.priority_req),
            .i_new_cell   (i_in.cell_index),
            .i_left_place (left_place),
            .i_left_prio  (left_prio),
            .i_left_cell  (left_cell),
            .i_right_prio (right_prio),
            .i_right_cell (right_cell),
            .o_place      (place[k]),
            .o_prio       (slot_prio[k]),
            .o_cell       (slot_cell[k])
        );
    end

    // Result: the head after the item, zeroed when the queue is empty.
    assign o_out.valid         = r_out_valid;
    assign o_out.head_valid    = !is_empty;
    assign o_out.head_cell     = is_empty ? '0 : slot_cell[0];
    assign o_out.head_priority = is_empty ? '0 : slot_prio[0];
    assign o_out.entry_count   = r_count;
    assign o_out.status        = r_status;

endmodule

`default_nettype wire
